// File: design/steq_pkg.sv
// Package for the sorted timer event queue: request, response and entry
// types, command and result-kind codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package steq_pkg;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_RUN    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_NONE  = 2'd2,
    KIND_FIND  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] delay_seconds;
    logic [7:0]  callback_id;
    logic [15:0] data_id;
    logic [31:0] new_time;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  fired_callback;
    logic [15:0] fired_data;
    logic [31:0] fired_time;
    logic        found;
    logic        full_error;
    logic [4:0]  pending_count;
    logic [31:0] served_count;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [31:0] deadline;
    logic [7:0]  callback;
    logic [15:0] data;
  } entry_t;

endpackage

`default_nettype wire

// File: design/steq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module steq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/sorted_timer_event_queue.sv
// Sorted timer event queue: top level with the command sequencer.
// Depends on steq_pkg and steq_ram (entry storage).
//
//   channel   handshake          payload  behavior
//   request   start, busy        req_t    taken at an edge with start high and busy low
//   response  rsp_strobe         rsp_t    one cycle per response, cannot be held off
//
// Add: entries are read from the top down and each later entry is moved up
// one slot, until an entry with an earlier or equal deadline or the bottom
// ends the search; then the new entry is written. Cancel and find: one RAM
// read per entry. Run: due entries are counted from the front until every
// entry is due or a later entry ends the scan; when anything fires, a
// fire-and-compact pass follows over all entries pending before the run.
// All of these go through the single RAM read port.
// Synchronous reset clears counts and time; the entry RAM is not cleared.
// Responses cannot be stalled; a finished response overlaps the next request.
`timescale 1ns / 1ps
`default_nettype none

module sorted_timer_event_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire steq_pkg::req_t req,
  output logic                busy,
  output logic                rsp_strobe,
  output steq_pkg::rsp_t      rsp
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = $bits(steq_pkg::entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_CHK,
    S_ADD_PUT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_CMP_RD,
    S_CMP_CHK
  } state_t;

  state_t          state;
  steq_pkg::req_t  cur;
  logic [31:0]     dl;
  logic [31:0]     present_time;
  logic [31:0]     fired_total;
  logic [CW-1:0]   count;
  logic [CW-1:0]   limit;
  logic [CW-1:0]   due;
  logic [CW-1:0]   r;
  logic [CW-1:0]   w;
  logic [CW-1:0]   ptr;
  logic            found;

  logic            we;
  logic [IW-1:0]   waddr;
  logic [IW-1:0]   raddr;
  steq_pkg::entry_t wdata;
  steq_pkg::entry_t rdata;
  logic [EW-1:0]   rdata_raw;

  logic            due_now;
  logic            later;
  logic            hit;
  logic            pair_match;
  logic            scan_stop;
  logic [CW-1:0]   ptr_dec;

  logic            rsp_strobe_next;
  steq_pkg::rsp_t  rsp_next;

  function automatic steq_pkg::rsp_t pack_rsp(
    steq_pkg::kind_t kind, logic [7:0] cb, logic [15:0] data, logic [31:0] tm,
    logic fnd, logic full, logic [4:0] pending, logic [31:0] served, logic fin);
    steq_pkg::rsp_t p;
    p.kind           = kind;
    p.fired_callback = cb;
    p.fired_data     = data;
    p.fired_time     = tm;
    p.found          = fnd;
    p.full_error     = full;
    p.pending_count  = pending;
    p.served_count   = served;
    p.last           = fin;
    return p;
  endfunction

  steq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH), .AW(IW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign rdata = steq_pkg::entry_t'(rdata_raw);
  assign busy  = (state != S_IDLE);

  always_comb begin
    ptr_dec    = ptr - 1'b1;
    due_now    = (rdata.deadline <= cur.new_time);
    later      = (rdata.deadline > dl);
    pair_match = (rdata.callback == cur.callback_id) && (rdata.data == cur.data_id);
    hit        = 1'b0;
    case (steq_pkg::cmd_t'(cur.cmd))
      steq_pkg::CMD_CANCEL: begin
        hit = ((cur.callback_id == 8'd0) && (rdata.data == cur.data_id)) ||
              ((cur.callback_id != 8'd0) && (cur.data_id != 16'd0) &&
               (rdata.data == cur.data_id)) ||
              ((cur.data_id == 16'd0) && (rdata.callback == cur.callback_id));
      end
      steq_pkg::CMD_RUN: hit = (r < due);
      default:           hit = 1'b0;
    endcase
    scan_stop = ((state == S_SCAN_RD) && (r == count)) ||
                ((state == S_SCAN_CHK) && !due_now);

    we    = 1'b0;
    waddr = ptr[IW-1:0];
    wdata = rdata;
    raddr = r[IW-1:0];
    case (state)
      S_ADD_RD: raddr = ptr_dec[IW-1:0];
      S_ADD_CHK: begin
        // shift a later entry up one slot
        we    = later;
        waddr = ptr[IW-1:0];
        wdata = rdata;
      end
      S_ADD_PUT: begin
        we    = 1'b1;
        waddr = ptr[IW-1:0];
        wdata = '{deadline: dl, callback: cur.callback_id, data: cur.data_id};
      end
      S_CMP_CHK: begin
        // compact survivors down to the write pointer
        we    = !hit && (steq_pkg::cmd_t'(cur.cmd) != steq_pkg::CMD_FIND);
        waddr = w[IW-1:0];
        wdata = rdata;
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp_strobe_next = 1'b0;
    rsp_next        = pack_rsp(steq_pkg::KIND_ACK, 8'd0, 16'd0, 32'd0, 1'b0, 1'b0,
                               5'(count), fired_total, 1'b1);
    case (state)
      S_IDLE: begin
        // a full queue refuses the add at once
        rsp_strobe_next = start && (steq_pkg::cmd_t'(req.cmd) == steq_pkg::CMD_ADD) &&
                          (count == CW'(QUEUE_DEPTH));
        rsp_next        = pack_rsp(steq_pkg::KIND_ACK, 8'd0, 16'd0, 32'd0, 1'b0, 1'b1,
                                   5'(count), fired_total, 1'b1);
      end
      S_ADD_PUT: begin
        rsp_strobe_next = 1'b1;
        rsp_next        = pack_rsp(steq_pkg::KIND_ACK, 8'd0, 16'd0, 32'd0, 1'b0, 1'b0,
                                   5'(count + 1'b1), fired_total, 1'b1);
      end
      S_SCAN_RD, S_SCAN_CHK: begin
        rsp_strobe_next = scan_stop && (due == '0);
        rsp_next        = pack_rsp(steq_pkg::KIND_NONE, 8'd0, 16'd0, 32'd0, 1'b0, 1'b0,
                                   5'(count), fired_total, 1'b1);
      end
      S_CMP_RD: begin
        // fired results already went out during the pass
        rsp_strobe_next = (r == limit) &&
                          (steq_pkg::cmd_t'(cur.cmd) != steq_pkg::CMD_RUN);
        if (steq_pkg::cmd_t'(cur.cmd) == steq_pkg::CMD_FIND) begin
          rsp_next = pack_rsp(steq_pkg::KIND_FIND, 8'd0, 16'd0, 32'd0, found, 1'b0,
                              5'(count), fired_total, 1'b1);
        end else begin
          rsp_next = pack_rsp(steq_pkg::KIND_ACK, 8'd0, 16'd0, 32'd0, 1'b0, 1'b0,
                              5'(w), fired_total, 1'b1);
        end
      end
      S_CMP_CHK: begin
        rsp_strobe_next = (steq_pkg::cmd_t'(cur.cmd) == steq_pkg::CMD_RUN) && hit;
        rsp_next        = pack_rsp(steq_pkg::KIND_FIRED, rdata.callback, rdata.data,
                                   rdata.deadline, 1'b0, 1'b0, 5'(count), fired_total,
                                   (CW'(r + 1'b1) == due));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      present_time <= '0;
      fired_total  <= '0;
      rsp_strobe   <= 1'b0;
    end else begin
      rsp_strobe <= rsp_strobe_next;
      if (rsp_strobe_next) begin
        rsp <= rsp_next;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cur   <= req;
            dl    <= present_time + 32'(req.delay_seconds);
            r     <= '0;
            w     <= '0;
            due   <= '0;
            found <= 1'b0;
            limit <= count;
            ptr   <= count;
            case (steq_pkg::cmd_t'(req.cmd))
              steq_pkg::CMD_ADD: begin
                // a full queue stays idle
                if (count == '0) begin
                  state <= S_ADD_PUT;
                end else if (count != CW'(QUEUE_DEPTH)) begin
                  state <= S_ADD_RD;
                end
              end
              steq_pkg::CMD_RUN: state <= S_SCAN_RD;
              default:           state <= S_CMP_RD;
            endcase
          end
        end
        S_ADD_RD: state <= S_ADD_CHK;
        S_ADD_CHK: begin
          if (later) begin
            ptr   <= ptr_dec;
            state <= (ptr_dec == '0) ? S_ADD_PUT : S_ADD_RD;
          end else begin
            state <= S_ADD_PUT;
          end
        end
        S_ADD_PUT: begin
          count <= count + 1'b1;
          state <= S_IDLE;
        end
        S_SCAN_RD: begin
          if (!scan_stop) begin
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (!scan_stop) begin
            due   <= due + 1'b1;
            r     <= r + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_CMP_RD: begin
          if (r == limit) begin
            state <= S_IDLE;
            if (steq_pkg::cmd_t'(cur.cmd) == steq_pkg::CMD_CANCEL) begin
              count <= w;
            end
          end else begin
            state <= S_CMP_CHK;
          end
        end
        S_CMP_CHK: begin
          if (steq_pkg::cmd_t'(cur.cmd) == steq_pkg::CMD_FIND && pair_match) begin
            found <= 1'b1;
          end
          if (we) begin
            w <= w + 1'b1;
          end
          r     <= r + 1'b1;
          state <= S_CMP_RD;
        end
        default: state <= S_IDLE;
      endcase

      // close the scan: settle counts and time before any result goes out
      if (scan_stop) begin
        present_time <= cur.new_time;
        count        <= count - due;
        fired_total  <= fired_total + 32'(due);
        r            <= '0;
        w            <= '0;
        if (due == '0) begin
          state <= S_IDLE;
        end else begin
          state <= S_CMP_RD;
        end
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || rsp_strobe)
    else $error("accepted request neither started nor answered");

  a_fired_on_run: assert property (@(posedge clk) disable iff (rst)
    rsp_strobe && rsp.kind == steq_pkg::KIND_FIRED |->
      steq_pkg::cmd_t'(cur.cmd) == steq_pkg::CMD_RUN)
    else $error("fired event outside a run");

  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP_CHK |-> w <= r)
    else $error("compaction write pointer passed read pointer");

endmodule

`default_nettype wire
